### sv/irpe_pkg.sv
`default_nettype none

package irpe_pkg;

    // protocol codes
    localparam logic [2:0] PROTO_NEC    = 3'd0;
    localparam logic [2:0] PROTO_NECX   = 3'd1;
    localparam logic [2:0] PROTO_SONY12 = 3'd2;
    localparam logic [2:0] PROTO_SONY20 = 3'd3;
    localparam logic [2:0] PROTO_RC5    = 3'd4;

    // field limits
    localparam logic [15:0] NEC_ADDR_MAX    = 16'h00FF;
    localparam logic [15:0] NEC_CMD_MAX     = 16'h00FF;
    localparam logic [15:0] SONY12_ADDR_MAX = 16'h001F;
    localparam logic [15:0] SONY20_ADDR_MAX = 16'h1FFF;
    localparam logic [15:0] SONY_CMD_MAX    = 16'h007F;
    localparam logic [15:0] RC5_ADDR_MAX    = 16'h001F;
    localparam logic [15:0] RC5_CMD_MAX     = 16'h003F;

    // durations in microseconds
    localparam logic [13:0] NEC_HDR_MARK   = 14'd9000;
    localparam logic [12:0] NEC_HDR_SPACE  = 13'd4500;
    localparam logic [13:0] NEC_BIT_MARK   = 14'd560;
    localparam logic [12:0] NEC_ZERO_SPACE = 13'd560;
    localparam logic [12:0] NEC_ONE_SPACE  = 13'd1690;
    localparam logic [13:0] SONY_HDR_MARK  = 14'd2400;
    localparam logic [12:0] SONY_SPACE     = 13'd600;
    localparam logic [13:0] SONY_ONE_MARK  = 14'd1200;
    localparam logic [13:0] SONY_ZERO_MARK = 14'd600;
    localparam logic [13:0] RC5_HALF       = 14'd889;
    localparam logic [13:0] RC5_FULL       = 14'd1778;

    // carrier frequencies
    localparam logic [15:0] CARRIER_SONY = 16'd40000;
    localparam logic [15:0] CARRIER_RC5  = 16'd36000;
    localparam logic [15:0] CARRIER_STD  = 16'd38000;

    // last data bit index per protocol
    localparam logic [4:0] NEC_LAST_BIT    = 5'd31;
    localparam logic [4:0] SONY12_LAST_BIT = 5'd11;
    localparam logic [4:0] SONY20_LAST_BIT = 5'd19;

    // RC5 half-bit walk: half zero is the dropped leading space
    localparam int          RC5_BITS      = 14;
    localparam logic [4:0]  RC5_FIRST_HALF = 5'd1;
    localparam logic [4:0]  RC5_LAST_HALF  = 5'd27;
    localparam logic [3:0]  RC5_TOP_BIT    = 4'd13;

    typedef enum logic [1:0] {
        KIND_NEC,
        KIND_SONY,
        KIND_RC5
    } t_kind;

    typedef enum logic [2:0] {
        PAIR_ERR,
        PAIR_HDR,
        PAIR_BIT,
        PAIR_STOP,
        PAIR_RC5
    } t_pair_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_HDR,
        ST_BITS,
        ST_STOP,
        ST_RC5
    } t_state;

    typedef struct packed {
        logic      load;
        logic      emit;
        t_pair_sel sel;
        logic      last;
        logic      adv;
        logic      rc5_step;
    } t_cmd;

    typedef struct packed {
        logic  in_err;
        t_kind in_kind;
        t_kind kind;
        logic  bit_final;
        logic  rc5_pair;
        logic  rc5_end;
        logic  out_free;
    } t_sts;

    // duration of an RC5 run of one or two half-bits
    function automatic logic [13:0] rc5_dur(input logic [1:0] run);
        return (run == 2'd2) ? RC5_FULL : RC5_HALF;
    endfunction

    // line level of one RC5 half-bit; a one is space then mark
    function automatic logic rc5_level(input logic [RC5_BITS-1:0] bits, input logic [4:0] h);
        logic [3:0] j;
        logic       b;
        j = h[4:1];
        if (j > RC5_TOP_BIT) begin
            return 1'b0;
        end
        b = bits[RC5_TOP_BIT - j];
        return h[0] ? b : ~b;
    endfunction

endpackage

`default_nettype wire

### sv/irpe_ctrl.sv
`default_nettype none

module irpe_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  irpe_pkg::t_sts     i_sts,
    output irpe_pkg::t_cmd     o_cmd
);

    irpe_pkg::t_state r_state;
    irpe_pkg::t_state n_state;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= irpe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            irpe_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.in_err) begin
                        n_state = irpe_pkg::ST_ERR;
                    end else if (i_sts.in_kind == irpe_pkg::KIND_RC5) begin
                        n_state = irpe_pkg::ST_RC5;
                    end else begin
                        n_state = irpe_pkg::ST_HDR;
                    end
                end
            end
            irpe_pkg::ST_ERR: begin
                if (i_sts.out_free) n_state = irpe_pkg::ST_IDLE;
            end
            irpe_pkg::ST_HDR: begin
                if (i_sts.out_free) n_state = irpe_pkg::ST_BITS;
            end
            irpe_pkg::ST_BITS: begin
                if (i_sts.out_free && i_sts.bit_final) begin
                    n_state = (i_sts.kind == irpe_pkg::KIND_NEC) ? irpe_pkg::ST_STOP
                                                                 : irpe_pkg::ST_IDLE;
                end
            end
            irpe_pkg::ST_STOP: begin
                if (i_sts.out_free) n_state = irpe_pkg::ST_IDLE;
            end
            irpe_pkg::ST_RC5: begin
                if (i_sts.out_free && i_sts.rc5_end) n_state = irpe_pkg::ST_IDLE;
            end
            default: n_state = irpe_pkg::ST_IDLE;
        endcase
    end

    // drive datapath commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.sel  = irpe_pkg::PAIR_ERR;
        o_in_stall = (r_state != irpe_pkg::ST_IDLE);
        case (r_state)
            irpe_pkg::ST_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            irpe_pkg::ST_ERR: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.sel  = irpe_pkg::PAIR_ERR;
                o_cmd.last = 1'b1;
            end
            irpe_pkg::ST_HDR: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.sel  = irpe_pkg::PAIR_HDR;
            end
            irpe_pkg::ST_BITS: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.adv  = i_sts.out_free;
                o_cmd.sel  = irpe_pkg::PAIR_BIT;
                o_cmd.last = i_sts.bit_final && (i_sts.kind == irpe_pkg::KIND_SONY);
            end
            irpe_pkg::ST_STOP: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.sel  = irpe_pkg::PAIR_STOP;
                o_cmd.last = 1'b1;
            end
            irpe_pkg::ST_RC5: begin
                o_cmd.rc5_step = i_sts.out_free;
                o_cmd.emit     = i_sts.out_free && i_sts.rc5_pair;
                o_cmd.sel      = irpe_pkg::PAIR_RC5;
                o_cmd.last     = i_sts.rc5_end;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### sv/irpe_dp.sv
`default_nettype none

module irpe_dp (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [2:0]  i_protocol,
    input  wire logic [15:0] i_address,
    input  wire logic [15:0] i_command,
    input  wire logic        i_toggle,
    input  irpe_pkg::t_cmd   i_cmd,
    output irpe_pkg::t_sts   o_sts,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [13:0]      o_mark_us,
    output logic [12:0]      o_space_us,
    output logic [15:0]      o_carrier_hz,
    output logic             o_error,
    output logic             o_last
);

    irpe_pkg::t_kind r_kind;
    logic [31:0]     r_bits;
    logic [4:0]      r_idx;
    logic [4:0]      r_final;
    logic [15:0]     r_carrier;
    logic [4:0]      r_half;
    logic [1:0]      r_run;
    logic [1:0]      r_mark;
    logic            r_out_valid;

    irpe_pkg::t_kind n_kind;
    logic [31:0]     n_bits;
    logic [4:0]      n_final;
    logic [15:0]     n_carrier;
    logic            in_err;

    logic            lvl;
    logic            nxt_lvl;
    logic            rc5_end;
    logic            rc5_brk;
    logic [1:0]      run_now;
    logic [13:0]     run_dur;
    logic            cur_bit;
    logic [13:0]     pair_mark;
    logic [12:0]     pair_space;

    // decode and range-check the incoming request
    always_comb begin
        n_kind    = irpe_pkg::KIND_NEC;
        n_bits    = {~i_command[7:0], i_command[7:0], ~i_address[7:0], i_address[7:0]};
        n_final   = irpe_pkg::NEC_LAST_BIT;
        n_carrier = irpe_pkg::CARRIER_STD;
        in_err    = 1'b1;
        case (i_protocol)
            irpe_pkg::PROTO_NEC: begin
                in_err = (i_address > irpe_pkg::NEC_ADDR_MAX)
                      || (i_command > irpe_pkg::NEC_CMD_MAX);
            end
            irpe_pkg::PROTO_NECX: begin
                n_bits = {~i_command[7:0], i_command[7:0], i_address};
                in_err = (i_command > irpe_pkg::NEC_CMD_MAX);
            end
            irpe_pkg::PROTO_SONY12, irpe_pkg::PROTO_SONY20: begin
                n_kind    = irpe_pkg::KIND_SONY;
                n_bits    = {12'd0, i_address[12:0], i_command[6:0]};
                n_carrier = irpe_pkg::CARRIER_SONY;
                if (i_protocol == irpe_pkg::PROTO_SONY12) begin
                    n_final = irpe_pkg::SONY12_LAST_BIT;
                    in_err  = (i_address > irpe_pkg::SONY12_ADDR_MAX);
                end else begin
                    n_final = irpe_pkg::SONY20_LAST_BIT;
                    in_err  = (i_address > irpe_pkg::SONY20_ADDR_MAX);
                end
                in_err = in_err || (i_command > irpe_pkg::SONY_CMD_MAX);
            end
            irpe_pkg::PROTO_RC5: begin
                n_kind    = irpe_pkg::KIND_RC5;
                n_bits    = {18'd0, 2'b11, i_toggle, i_address[4:0], i_command[5:0]};
                n_carrier = irpe_pkg::CARRIER_RC5;
                in_err    = (i_address > irpe_pkg::RC5_ADDR_MAX)
                         || (i_command > irpe_pkg::RC5_CMD_MAX);
            end
            default: in_err = 1'b1;
        endcase
    end

    // walk RC5 half-bits, closing a run where the level changes or at the last half-bit
    always_comb begin
        lvl     = irpe_pkg::rc5_level(r_bits[irpe_pkg::RC5_BITS-1:0], r_half);
        nxt_lvl = irpe_pkg::rc5_level(r_bits[irpe_pkg::RC5_BITS-1:0], r_half + 5'd1);
        rc5_end = (r_half == irpe_pkg::RC5_LAST_HALF);
        rc5_brk = rc5_end || (nxt_lvl != lvl);
        run_now = r_run + 2'd1;
        run_dur = irpe_pkg::rc5_dur(run_now);
    end

    assign cur_bit = r_bits[r_idx];

    // select the pair to send
    always_comb begin
        pair_mark  = 14'd0;
        pair_space = 13'd0;
        case (i_cmd.sel)
            irpe_pkg::PAIR_ERR: begin
                pair_mark  = 14'd0;
                pair_space = 13'd0;
            end
            irpe_pkg::PAIR_HDR: begin
                if (r_kind == irpe_pkg::KIND_NEC) begin
                    pair_mark  = irpe_pkg::NEC_HDR_MARK;
                    pair_space = irpe_pkg::NEC_HDR_SPACE;
                end else begin
                    pair_mark  = irpe_pkg::SONY_HDR_MARK;
                    pair_space = irpe_pkg::SONY_SPACE;
                end
            end
            irpe_pkg::PAIR_BIT: begin
                if (r_kind == irpe_pkg::KIND_NEC) begin
                    pair_mark  = irpe_pkg::NEC_BIT_MARK;
                    pair_space = cur_bit ? irpe_pkg::NEC_ONE_SPACE : irpe_pkg::NEC_ZERO_SPACE;
                end else begin
                    pair_mark  = cur_bit ? irpe_pkg::SONY_ONE_MARK : irpe_pkg::SONY_ZERO_MARK;
                    pair_space = irpe_pkg::SONY_SPACE;
                end
            end
            irpe_pkg::PAIR_STOP: begin
                pair_mark  = irpe_pkg::NEC_BIT_MARK;
                pair_space = 13'd0;
            end
            irpe_pkg::PAIR_RC5: begin
                if (lvl) begin
                    pair_mark  = run_dur;
                    pair_space = 13'd0;
                end else begin
                    pair_mark  = irpe_pkg::rc5_dur(r_mark);
                    pair_space = run_dur[12:0];
                end
            end
            default: begin
                pair_mark  = 14'd0;
                pair_space = 13'd0;
            end
        endcase
    end

    // latch the request and advance the frame counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= n_kind;
            r_bits    <= n_bits;
            r_final   <= n_final;
            r_carrier <= n_carrier;
            r_idx     <= 5'd0;
            r_half    <= irpe_pkg::RC5_FIRST_HALF;
            r_run     <= 2'd0;
            r_mark    <= 2'd0;
        end else begin
            if (i_cmd.adv) begin
                r_idx <= r_idx + 5'd1;
            end
            if (i_cmd.rc5_step) begin
                r_half <= r_half + 5'd1;
                if (rc5_brk) begin
                    r_run <= 2'd0;
                    if (lvl) r_mark <= run_now;
                end else begin
                    r_run <= run_now;
                end
            end
        end
    end

    // hold the output item until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_mark_us    <= pair_mark;
            o_space_us   <= pair_space;
            o_carrier_hz <= r_carrier;
            o_error      <= (i_cmd.sel == irpe_pkg::PAIR_ERR);
            o_last       <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;

    // report status to the controller
    always_comb begin
        o_sts           = '0;
        o_sts.in_err    = in_err;
        o_sts.in_kind   = n_kind;
        o_sts.kind      = r_kind;
        o_sts.bit_final = (r_idx == r_final);
        o_sts.rc5_pair  = rc5_brk && (!lvl || rc5_end);
        o_sts.rc5_end   = rc5_end;
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

endmodule

`default_nettype wire

### sv/ir_remote_pulse_encoder.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_protocol, i_address, i_command, i_toggle
// out       output     o_out_valid / i_out_stall o_mark_us, o_space_us, o_carrier_hz,
//                                                o_error, o_last
//
// One frame request is worked at a time. While the output register is free, the sequencer
// sends one pair per cycle (NEC 34 pairs), or for RC5 walks one half-bit a cycle and sends
// a pair where a run closes; an error request gives a single error item.
// o_in_stall is high from acceptance until the last pair is loaded into the output register.
// A stalled output register holds the sequencer in place; nothing is dropped.
// Reset is synchronous, active low, and clears the controller and output valid.

module ir_remote_pulse_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_protocol,
    input  wire logic [15:0] i_address,
    input  wire logic [15:0] i_command,
    input  wire logic        i_toggle,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [13:0]      o_mark_us,
    output logic [12:0]      o_space_us,
    output logic [15:0]      o_carrier_hz,
    output logic             o_error,
    output logic             o_last
);

    irpe_pkg::t_cmd cmd;
    irpe_pkg::t_sts sts;

    irpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    irpe_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_protocol   (i_protocol),
        .i_address    (i_address),
        .i_command    (i_command),
        .i_toggle     (i_toggle),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_mark_us    (o_mark_us),
        .o_space_us   (o_space_us),
        .o_carrier_hz (o_carrier_hz),
        .o_error      (o_error),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

### sv/irpe_checker.sv
`default_nettype none

module irpe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [13:0] o_mark_us,
    input wire logic [12:0] o_space_us,
    input wire logic [15:0] o_carrier_hz,
    input wire logic        o_error,
    input wire logic        o_last
);

    // an error item is the whole frame
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_last)
        else $error("error item without last");

    // an error item carries no durations
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> (o_mark_us == 14'd0) && (o_space_us == 13'd0))
        else $error("error item with nonzero duration");

    // a valid frame pair always has a mark
    a_mark_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_error |-> (o_mark_us != 14'd0))
        else $error("frame pair without mark");

    // an accepted request keeps the input stalled while it is worked
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after acceptance");

    // a stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_mark_us)
            && $stable(o_space_us) && $stable(o_carrier_hz) && $stable(o_last)
            && $stable(o_error))
        else $error("stalled output item changed");

endmodule

bind ir_remote_pulse_encoder irpe_checker u_irpe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_mark_us    (o_mark_us),
    .o_space_us   (o_space_us),
    .o_carrier_hz (o_carrier_hz),
    .o_error      (o_error),
    .o_last       (o_last)
);

`default_nettype wire
